// File: rtl/core/point_segment_distance_3d_defines.svh
`ifndef POINT_SEGMENT_DISTANCE_3D_DEFINES_SVH
`define POINT_SEGMENT_DISTANCE_3D_DEFINES_SVH

// property checked every clock, off while reset is asserted
`define PSD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// condition now implies a consequence on the next clock
`define PSD_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) else $error(msg);

`endif

// File: rtl/core/psd_pkg.sv
package psd_pkg;

  localparam int DIST_W      = 17;
  localparam int NORM_W      = 55;
  localparam int QUOT_BITS   = 2 * DIST_W;
  localparam int QUEUE_DEPTH = 4;
  localparam int CFG_IDX_W   = 3;

  localparam logic [DIST_W-1:0] DIST_MAX = '1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_END_A_X = 3'd0,
    CFG_END_A_Y = 3'd1,
    CFG_END_A_Z = 3'd2,
    CFG_END_B_X = 3'd3,
    CFG_END_B_Y = 3'd4,
    CFG_END_B_Z = 3'd5
  } cfg_idx_e;

  // per-item flags and normal, carried alongside the divider and root pipes
  typedef struct packed {
    logic              in_bounds;
    logic              degen;
    logic              ovf;
    logic [NORM_W-1:0] nx;
    logic [NORM_W-1:0] ny;
    logic [NORM_W-1:0] nz;
  } psd_side_t;

endpackage

// File: rtl/core/psd_ifs.sv
interface psd_point_if #(
  parameter int CoordW = 16
) ();
  logic              valid;
  logic              ready;
  logic [CoordW-1:0] point_x;
  logic [CoordW-1:0] point_y;
  logic [CoordW-1:0] point_z;

  modport source (output valid, output point_x, output point_y, output point_z,
                  input ready);
  modport sink (input valid, input point_x, input point_y, input point_z,
                output ready);
endinterface

interface psd_result_if ();
  logic                         valid;
  logic                         ready;
  logic [psd_pkg::DIST_W-1:0]   line_distance;
  logic                         in_bounds;
  logic [psd_pkg::NORM_W-1:0]   normal_x;
  logic [psd_pkg::NORM_W-1:0]   normal_y;
  logic [psd_pkg::NORM_W-1:0]   normal_z;
  logic                         degenerate;

  modport source (output valid, output line_distance, output in_bounds,
                  output normal_x, output normal_y, output normal_z,
                  output degenerate, input ready);
  modport sink (input valid, input line_distance, input in_bounds,
                input normal_x, input normal_y, input normal_z,
                input degenerate, output ready);
endinterface

interface psd_cfg_if #(
  parameter int CoordW = 16
) ();
  logic                          valid;
  logic                          ready;
  logic [psd_pkg::CFG_IDX_W-1:0] index;
  logic [CoordW-1:0]             data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// File: rtl/core/point_segment_distance_3d.sv
// pipeline: after the point is accepted the result passes 5 product stages,
// 34 divider stages, 17 root stages and the output register
// throughput: one point per cycle sustained; a stalled output freezes the back pipe
// and the 4-entry queue absorbs up to four more points before ready drops
// reset: asynchronous active low; clears valids and queue, endpoints go to a=(0,0,0),
// b=(1.0,0,0); no clearing pass, block is ready as soon as reset is released
module point_segment_distance_3d #(
  parameter int COORD_WIDTH = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  psd_cfg_if.sink      cfg_i,
  psd_point_if.sink    point_i,
  psd_result_if.source result_o
);
  // queue entry: degenerate flag plus b-a, p-a and b-p, each one bit wider than a coordinate
  localparam int EntW = 9 * (COORD_WIDTH + 1) + 1;

  logic [COORD_WIDTH-1:0] end_a_q [3];
  logic [COORD_WIDTH-1:0] end_b_q [3];

  // config writes always accepted; unused indexes fall to the default arm
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      end_a_q[0] <= '0;
      end_a_q[1] <= '0;
      end_a_q[2] <= '0;
      end_b_q[0] <= COORD_WIDTH'(256);
      end_b_q[1] <= '0;
      end_b_q[2] <= '0;
    end else if (cfg_i.valid) begin
      case (psd_pkg::cfg_idx_e'(cfg_i.index))
        psd_pkg::CFG_END_A_X: begin
          end_a_q[0] <= cfg_i.data;
        end
        psd_pkg::CFG_END_A_Y: begin
          end_a_q[1] <= cfg_i.data;
        end
        psd_pkg::CFG_END_A_Z: begin
          end_a_q[2] <= cfg_i.data;
        end
        psd_pkg::CFG_END_B_X: begin
          end_b_q[0] <= cfg_i.data;
        end
        psd_pkg::CFG_END_B_Y: begin
          end_b_q[1] <= cfg_i.data;
        end
        psd_pkg::CFG_END_B_Z: begin
          end_b_q[2] <= cfg_i.data;
        end
        default: begin
        end
      endcase
    end
  end

  // front: differences and degenerate check, pushes straight into the queue
  logic            push, full, q_valid, pop;
  logic [EntW-1:0] ent, q_data;

  psd_front #(
    .CoordW (COORD_WIDTH),
    .EntW   (EntW)
  ) u_front (
    .end_a_i (end_a_q),
    .end_b_i (end_b_q),
    .point_i (point_i),
    .full_i  (full),
    .push_o  (push),
    .ent_o   (ent)
  );

  // short queue lets front keep taking points while the back pipe is stalled
  psd_queue #(
    .DataW (EntW),
    .Depth (psd_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (ent),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .data_o  (q_data)
  );

  // back: products, 34-stage divider, 17-stage root, output register
  psd_back #(
    .CoordW (COORD_WIDTH),
    .EntW   (EntW)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_valid),
    .q_data_i  (q_data),
    .pop_o     (pop),
    .result_o  (result_o)
  );

endmodule

// File: rtl/core/psd_queue.sv
`include "point_segment_distance_3d_defines.svh"

module psd_queue #(
  parameter int DataW = 154,
  parameter int Depth = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [DataW-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output logic [DataW-1:0] data_o
);
  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  logic [DataW-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]  cnt_q;
  logic             push, pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign valid_o = (cnt_q != '0);
  assign push    = push_i && !full_o;
  assign pop     = pop_i && valid_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  `PSD_ASSERT(a_cnt_range, cnt_q <= CntW'(Depth), "queue fill count above depth")
  `PSD_ASSERT_NEXT(a_cnt_grow, push && !pop, cnt_q == $past(cnt_q) + 1'b1, "queue count did not grow")
  `PSD_ASSERT_NEXT(a_cnt_shrink, pop && !push, cnt_q == $past(cnt_q) - 1'b1, "queue count did not shrink")

endmodule

// File: rtl/core/psd_front.sv
module psd_front #(
  parameter int CoordW = 16,
  parameter int EntW   = 9 * (CoordW + 1) + 1
) (
  input  logic [CoordW-1:0] end_a_i [3],
  input  logic [CoordW-1:0] end_b_i [3],
  psd_point_if.sink         point_i,
  input  logic              full_i,
  output logic              push_o,
  output logic [EntW-1:0]   ent_o
);
  localparam int DW = CoordW + 1;

  logic signed [DW-1:0] l [3];
  logic signed [DW-1:0] u [3];
  logic signed [DW-1:0] v [3];
  logic [CoordW-1:0]    p [3];
  logic                 degen;

  assign p[0] = point_i.point_x;
  assign p[1] = point_i.point_y;
  assign p[2] = point_i.point_z;

  // l = b - a, u = p - a, v = b - p
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      l[i] = $signed({end_b_i[i][CoordW-1], end_b_i[i]})
           - $signed({end_a_i[i][CoordW-1], end_a_i[i]});
      u[i] = $signed({p[i][CoordW-1], p[i]})
           - $signed({end_a_i[i][CoordW-1], end_a_i[i]});
      v[i] = $signed({end_b_i[i][CoordW-1], end_b_i[i]})
           - $signed({p[i][CoordW-1], p[i]});
    end
  end

  assign degen         = (l[0] == '0) && (l[1] == '0) && (l[2] == '0);
  assign point_i.ready = !full_i;
  assign push_o        = point_i.valid && !full_i;
  assign ent_o         = {degen, l[0], l[1], l[2], u[0], u[1], u[2], v[0], v[1], v[2]};

endmodule

// File: rtl/core/psd_back.sv
`include "point_segment_distance_3d_defines.svh"

module psd_back #(
  parameter int CoordW = 16,
  parameter int EntW   = 9 * (CoordW + 1) + 1
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            q_valid_i,
  input  logic [EntW-1:0] q_data_i,
  output logic            pop_o,
  psd_result_if.source    result_o
);
  localparam int DW    = CoordW + 1;
  localparam int PW    = 2 * DW;
  localparam int CW    = PW + 1;
  localparam int DOTW  = PW + 2;
  localparam int LSQW  = PW + 2;
  localparam int NPW   = DW + CW;
  localparam int NSQW  = 2 * CW + 2;
  localparam int NORMW = psd_pkg::NORM_W;
  localparam int NXW   = (NPW + 1 > NORMW) ? NPW + 1 : NORMW;
  localparam int QB    = psd_pkg::QUOT_BITS;
  localparam int RW    = psd_pkg::DIST_W;
  localparam int SQN   = psd_pkg::DIST_W;
  localparam int SRW   = RW + 4;
  localparam int NST   = 5 + QB + SQN + 1;

  logic           en;
  logic [NST-1:0] vld_q;

  assign en    = !vld_q[NST-1] || result_o.ready;
  assign pop_o = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[NST-2:0], q_valid_i};
    end
  end

  // unpack queue entry
  logic signed [DW-1:0] lx, ly, lz, ux, uy, uz, vx, vy, vz;
  logic                 dg;
  assign {dg, lx, ly, lz, ux, uy, uz, vx, vy, vz} = q_data_i;

  // stage 1: first-level products
  logic signed [PW-1:0] s1_da_q [3];
  logic signed [PW-1:0] s1_db_q [3];
  logic signed [PW-1:0] s1_cp_q [6];
  logic signed [PW-1:0] s1_sq_q [3];
  logic signed [DW-1:0] s1_l_q  [3];
  logic                 s1_dg_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_da_q[0] <= ux * lx;
      s1_da_q[1] <= uy * ly;
      s1_da_q[2] <= uz * lz;
      s1_db_q[0] <= vx * lx;
      s1_db_q[1] <= vy * ly;
      s1_db_q[2] <= vz * lz;
      s1_cp_q[0] <= ly * uz;
      s1_cp_q[1] <= lz * uy;
      s1_cp_q[2] <= lz * ux;
      s1_cp_q[3] <= lx * uz;
      s1_cp_q[4] <= lx * uy;
      s1_cp_q[5] <= ly * ux;
      s1_sq_q[0] <= lx * lx;
      s1_sq_q[1] <= ly * ly;
      s1_sq_q[2] <= lz * lz;
      s1_l_q[0]  <= lx;
      s1_l_q[1]  <= ly;
      s1_l_q[2]  <= lz;
      s1_dg_q    <= dg;
    end
  end

  // stage 2: dots, cross product, squared length
  logic signed [DOTW-1:0] s2_dota_q, s2_dotb_q;
  logic signed [CW-1:0]   s2_c_q [3];
  logic [LSQW-1:0]        s2_lsq_q;
  logic signed [DW-1:0]   s2_l_q [3];
  logic                   s2_dg_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      s2_dota_q <= DOTW'(s1_da_q[0]) + DOTW'(s1_da_q[1]) + DOTW'(s1_da_q[2]);
      s2_dotb_q <= DOTW'(s1_db_q[0]) + DOTW'(s1_db_q[1]) + DOTW'(s1_db_q[2]);
      s2_c_q[0] <= CW'(s1_cp_q[0]) - CW'(s1_cp_q[1]);
      s2_c_q[1] <= CW'(s1_cp_q[2]) - CW'(s1_cp_q[3]);
      s2_c_q[2] <= CW'(s1_cp_q[4]) - CW'(s1_cp_q[5]);
      s2_lsq_q  <= LSQW'(s1_sq_q[0]) + LSQW'(s1_sq_q[1]) + LSQW'(s1_sq_q[2]);
      s2_l_q    <= s1_l_q;
      s2_dg_q   <= s1_dg_q;
    end
  end

  // stage 3: normal products, cross squares, bounds flag
  logic signed [NPW-1:0]  s3_np_q [6];
  logic signed [2*CW-1:0] s3_cs_q [3];
  logic [LSQW-1:0]        s3_lsq_q;
  logic                   s3_ib_q, s3_dg_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      s3_np_q[0] <= s2_l_q[1] * s2_c_q[2];
      s3_np_q[1] <= s2_l_q[2] * s2_c_q[1];
      s3_np_q[2] <= s2_l_q[2] * s2_c_q[0];
      s3_np_q[3] <= s2_l_q[0] * s2_c_q[2];
      s3_np_q[4] <= s2_l_q[0] * s2_c_q[1];
      s3_np_q[5] <= s2_l_q[1] * s2_c_q[0];
      s3_cs_q[0] <= s2_c_q[0] * s2_c_q[0];
      s3_cs_q[1] <= s2_c_q[1] * s2_c_q[1];
      s3_cs_q[2] <= s2_c_q[2] * s2_c_q[2];
      s3_lsq_q   <= s2_lsq_q;
      s3_ib_q    <= !s2_dota_q[DOTW-1] && (s2_dota_q != '0)
                 && !s2_dotb_q[DOTW-1] && (s2_dotb_q != '0);
      s3_dg_q    <= s2_dg_q;
    end
  end

  // stage 4: normal differences, squared cross length
  logic signed [NXW-1:0] n_full [3];
  logic [NSQW-1:0]       s4_nsq_q;
  logic [LSQW-1:0]       s4_lsq_q;
  psd_pkg::psd_side_t    s4_side_q;

  assign n_full[0] = NXW'(s3_np_q[0]) - NXW'(s3_np_q[1]);
  assign n_full[1] = NXW'(s3_np_q[2]) - NXW'(s3_np_q[3]);
  assign n_full[2] = NXW'(s3_np_q[4]) - NXW'(s3_np_q[5]);

  always_ff @(posedge clk_i) begin
    if (en) begin
      s4_nsq_q            <= NSQW'(s3_cs_q[0]) + NSQW'(s3_cs_q[1]) + NSQW'(s3_cs_q[2]);
      s4_lsq_q            <= s3_lsq_q;
      s4_side_q.in_bounds <= s3_ib_q;
      s4_side_q.degen     <= s3_dg_q;
      s4_side_q.ovf       <= 1'b0;
      s4_side_q.nx        <= n_full[0][NORMW-1:0];
      s4_side_q.ny        <= n_full[1][NORMW-1:0];
      s4_side_q.nz        <= n_full[2][NORMW-1:0];
    end
  end

  // stage 5: quotient overflow check, divider seed
  logic [LSQW-1:0]    s5_r_q, s5_d_q;
  logic [QB-1:0]      s5_n_q;
  psd_pkg::psd_side_t s5_side_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      s5_r_q              <= LSQW'(s4_nsq_q >> QB);
      s5_d_q              <= s4_lsq_q;
      s5_n_q              <= s4_nsq_q[QB-1:0];
      s5_side_q.in_bounds <= s4_side_q.in_bounds;
      s5_side_q.degen     <= s4_side_q.degen;
      s5_side_q.ovf       <= (s4_nsq_q >> QB) >= NSQW'(s4_lsq_q);
      s5_side_q.nx        <= s4_side_q.nx;
      s5_side_q.ny        <= s4_side_q.ny;
      s5_side_q.nz        <= s4_side_q.nz;
    end
  end

  // restoring divider, one quotient bit per stage
  logic [LSQW-1:0]    dv_r_q [QB];
  logic [LSQW-1:0]    dv_d_q [QB];
  logic [QB-1:0]      dv_n_q [QB];
  logic [QB-1:0]      dv_q_q [QB];
  psd_pkg::psd_side_t dv_s_q [QB];

  for (genvar k = 0; k < QB; k++) begin : g_div
    logic [LSQW-1:0]    r_in, d_in;
    logic [QB-1:0]      n_in, q_in;
    psd_pkg::psd_side_t s_in;
    logic [LSQW:0]      t;
    logic               ge;

    if (k == 0) begin : g_first
      assign r_in = s5_r_q;
      assign d_in = s5_d_q;
      assign n_in = s5_n_q;
      assign q_in = '0;
      assign s_in = s5_side_q;
    end else begin : g_next
      assign r_in = dv_r_q[k-1];
      assign d_in = dv_d_q[k-1];
      assign n_in = dv_n_q[k-1];
      assign q_in = dv_q_q[k-1];
      assign s_in = dv_s_q[k-1];
    end

    assign t  = {r_in, n_in[QB-1]};
    assign ge = t >= {1'b0, d_in};

    always_ff @(posedge clk_i) begin
      if (en) begin
        dv_r_q[k] <= ge ? LSQW'(t - {1'b0, d_in}) : t[LSQW-1:0];
        dv_d_q[k] <= d_in;
        dv_n_q[k] <= {n_in[QB-2:0], 1'b0};
        dv_q_q[k] <= {q_in[QB-2:0], ge};
        dv_s_q[k] <= s_in;
      end
    end
  end

  // digit-by-digit square root, two radicand bits per stage
  logic [SRW-1:0]     sq_rem_q  [SQN];
  logic [RW-1:0]      sq_root_q [SQN];
  logic [QB-1:0]      sq_x_q    [SQN];
  psd_pkg::psd_side_t sq_s_q    [SQN];

  for (genvar j = 0; j < SQN; j++) begin : g_sqrt
    logic [SRW-1:0]     rem_in, rem2, trial;
    logic [RW-1:0]      root_in;
    logic [QB-1:0]      x_in;
    psd_pkg::psd_side_t s_in;
    logic               ge;

    if (j == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign x_in    = dv_q_q[QB-1];
      assign s_in    = dv_s_q[QB-1];
    end else begin : g_next
      assign rem_in  = sq_rem_q[j-1];
      assign root_in = sq_root_q[j-1];
      assign x_in    = sq_x_q[j-1];
      assign s_in    = sq_s_q[j-1];
    end

    assign rem2  = {rem_in[SRW-3:0], x_in[QB-1 -: 2]};
    assign trial = SRW'({root_in, 2'b01});
    assign ge    = rem2 >= trial;

    always_ff @(posedge clk_i) begin
      if (en) begin
        sq_rem_q[j]  <= ge ? rem2 - trial : rem2;
        sq_root_q[j] <= {root_in[RW-2:0], ge};
        sq_x_q[j]    <= {x_in[QB-3:0], 2'b00};
        sq_s_q[j]    <= s_in;
      end
    end
  end

  // output register
  logic [RW-1:0]      out_dist_q;
  psd_pkg::psd_side_t out_side_q;
  logic [RW-1:0]      dist_d;

  always_comb begin
    if (sq_s_q[SQN-1].degen) begin
      dist_d = '0;
    end else if (sq_s_q[SQN-1].ovf) begin
      dist_d = psd_pkg::DIST_MAX;
    end else begin
      dist_d = sq_root_q[SQN-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_dist_q <= dist_d;
      out_side_q <= sq_s_q[SQN-1];
    end
  end

  assign result_o.valid         = vld_q[NST-1];
  assign result_o.line_distance = out_dist_q;
  assign result_o.in_bounds     = out_side_q.in_bounds;
  assign result_o.normal_x      = out_side_q.nx;
  assign result_o.normal_y      = out_side_q.ny;
  assign result_o.normal_z      = out_side_q.nz;
  assign result_o.degenerate    = out_side_q.degen;

  `PSD_ASSERT(a_degen_zero, (vld_q[NST-1] && out_side_q.degen) |-> (out_dist_q == '0), "degenerate result with nonzero distance")

endmodule
